@@ rtl/core/bcm_pkg.sv @@
// ----------------------------------------------------------------------------
// bcm_pkg: shared definitions of the binomial coefficient unit
// Widths of the arguments, the running value and the serial units' counters,
// and the status bundle that the serial units report to the sequencer.
// ----------------------------------------------------------------------------
package bcm_pkg;

	localparam int ARG_BITS     = 16;
	localparam int ACC_BITS     = 64;
	localparam int PROD_BITS    = ACC_BITS + ARG_BITS;
	localparam int MUL_CNT_BITS = $clog2(ARG_BITS + 1);
	localparam int DIV_CNT_BITS = $clog2(ACC_BITS + 1);

	typedef logic [ARG_BITS-1:0]  arg_t;
	typedef logic [ACC_BITS-1:0]  acc_t;
	typedef logic [PROD_BITS-1:0] prod_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

@@ rtl/core/bcm_mul.sv @@
// ----------------------------------------------------------------------------
// bcm_mul: bit-serial multiplier
// Forms the full product of the running value and one factor, taking one
// factor bit per cycle from the top down with a shift and an add.
// ----------------------------------------------------------------------------
module bcm_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  bcm_pkg::acc_t         multiplicand,
	input  bcm_pkg::arg_t         multiplier,
	output bcm_pkg::prod_t        product,
	output bcm_pkg::unit_status_t status
);
	import bcm_pkg::*;

	acc_t                    mcand_q;
	arg_t                    mplier_q;
	prod_t                   prod_q;
	prod_t                   addend;
	logic [MUL_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;

	assign addend = mplier_q[ARG_BITS-1] ? PROD_BITS'(mcand_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_BITS'(ARG_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= multiplicand;
			mplier_q <= multiplier;
			prod_q   <= '0;
		end else if (busy_q) begin
			prod_q   <= {prod_q[PROD_BITS-2:0], 1'b0} + addend;
			mplier_q <= {mplier_q[ARG_BITS-2:0], 1'b0};
		end
	end

	assign product     = prod_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ rtl/core/bcm_div.sv @@
// ----------------------------------------------------------------------------
// bcm_div: bit-serial restoring divider
// Divides the 64-bit product by the step index, one quotient bit per cycle.
// The quotient shifts in where the dividend shifts out.
// ----------------------------------------------------------------------------
module bcm_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  bcm_pkg::acc_t         dividend,
	input  bcm_pkg::arg_t         divisor,
	output bcm_pkg::acc_t         quotient,
	output bcm_pkg::unit_status_t status
);
	import bcm_pkg::*;

	acc_t                    quo_q;
	arg_t                    div_q;
	arg_t                    rem_q;
	logic [ARG_BITS:0]       trial;
	logic [ARG_BITS:0]       diff;
	logic                    fits;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;

	assign trial = {rem_q, quo_q[ACC_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(ACC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits in ARG_BITS.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ARG_BITS-1:0] : trial[ARG_BITS-1:0];
			quo_q <= {quo_q[ACC_BITS-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

@@ rtl/core/binomial_coefficient_multiplicative_unit.sv @@
// ----------------------------------------------------------------------------
// binomial_coefficient_multiplicative_unit: n choose k by the product formula
// An item on the input channel carries n_value and k_value; the block answers
// with one item holding coefficient (64 bits) and overflow. For each step j
// from 1 to k the running value is multiplied by n-k+j in a bit-serial
// multiplier and divided exactly by j in a bit-serial divider. When the
// product grows past 64 bits the block stops early with overflow set and
// coefficient 0. The trivial cases (k zero, k equal to n, k greater than n)
// skip the multiplier and divider and go from idle straight to the finish state.
// One item is worked on at a time; in_stall is high from acceptance until the
// result has moved into the output register. The output register holds the
// result while out_stall is high, and a new item may be accepted meanwhile.
// Reset clears the sequencer, the output valid flag and the output result;
// an item in work or a result held in the output register is dropped by it.
// ----------------------------------------------------------------------------
module binomial_coefficient_multiplicative_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bcm_pkg::arg_t n_value,
	input  bcm_pkg::arg_t k_value,
	output logic          out_valid,
	input  logic          out_stall,
	output bcm_pkg::acc_t coefficient,
	output logic          overflow
);
	import bcm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t       state_q;
	arg_t         n_q;
	arg_t         k_q;
	arg_t         j_q;
	arg_t         factor_q;
	acc_t         acc_q;
	acc_t         res_q;
	logic         res_ovf_q;
	logic         mul_start_q;
	logic         div_start_q;
	logic         out_valid_q;
	acc_t         coef_q;
	logic         ovf_q;

	prod_t        product;
	acc_t         quotient;
	unit_status_t mul_st;
	unit_status_t div_st;
	logic         in_accept;
	logic         out_free;

	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	bcm_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start_q),
		.multiplicand (acc_q),
		.multiplier   (factor_q),
		.product      (product),
		.status       (mul_st)
	);

	bcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (product[ACC_BITS-1:0]),
		.divisor  (j_q),
		.quotient (quotient),
		.status   (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			coef_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			// A result leaving while the sequencer finishes is replaced below.
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (k_value == '0 || k_value == n_value || k_value > n_value) begin
							state_q <= ST_FINISH;
						end else begin
							mul_start_q <= 1'b1;
							state_q     <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mul_st.done) begin
						if (product[PROD_BITS-1:ACC_BITS] != '0) begin
							state_q <= ST_FINISH;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						if (j_q == k_q) begin
							state_q <= ST_FINISH;
						end else begin
							mul_start_q <= 1'b1;
							state_q     <= ST_MUL;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						coef_q      <= res_q;
						ovf_q       <= res_ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand and result registers follow the sequencer's state.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					n_q       <= n_value;
					k_q       <= k_value;
					j_q       <= arg_t'(1);
					acc_q     <= acc_t'(1);
					factor_q  <= n_value - k_value + arg_t'(1);
					res_ovf_q <= 1'b0;
					if (k_value == '0 || k_value == n_value) begin
						res_q <= acc_t'(1);
					end else begin
						res_q <= '0;
					end
				end
			end
			ST_MUL: begin
				if (mul_st.done && product[PROD_BITS-1:ACC_BITS] != '0) begin
					res_q     <= '0;
					res_ovf_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					acc_q    <= quotient;
					res_q    <= quotient;
					j_q      <= j_q + arg_t'(1);
					factor_q <= n_q - k_q + j_q + arg_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;
	assign overflow    = ovf_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block did not go busy after accepting an item");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> coefficient == '0)
		else $error("overflow result carries a nonzero coefficient");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_st.busy && div_st.busy))
		else $error("multiplier and divider busy at once");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_DIV) |-> (j_q != '0 && j_q <= k_q))
		else $error("step index out of range");

endmodule

@@ dv/binomial_coefficient_multiplicative_unit_test.sv @@
// ----------------------------------------------------------------------------
// binomial_coefficient_multiplicative_unit_test: self-checking bench
// Sends n/k items through the valid/stall input channel and checks each result
// item against a local product-formula calculation: trivial cases, exact
// coefficients, early overflow and wide random arguments, with random idle
// bursts on both channels, a drained phase and a closing phase without idling.
// ----------------------------------------------------------------------------
module binomial_coefficient_multiplicative_unit_test;

	import bcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int MAX_RANDOM_STEPS = 70;
	localparam int END_DRAIN_CYCLES = 200;

	typedef struct {
		arg_t n;
		arg_t k;
		acc_t coefficient;
		logic overflow;
	} binom_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	arg_t n_value = '0;
	arg_t k_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	acc_t coefficient;
	logic overflow;

	binom_result_t pending_results[$];
	bit idling_on = 1'b1;
	int items_sent = 0;
	int results_checked = 0;
	int overflow_results = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	int out_stall_left = 0;

	binomial_coefficient_multiplicative_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.n_value    (n_value),
		.k_value    (k_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.coefficient(coefficient),
		.overflow   (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Product formula with a wide product, so a too-wide intermediate shows up
	// in the top bits. Also reports how many multiply/divide steps were run.
	function automatic void compute_binomial(input arg_t n, input arg_t k,
			output acc_t coef, output logic ovf, output int steps);
		acc_t acc;
		acc_t factor;
		prod_t prod;
		int unsigned j;
		coef = '0;
		ovf = 1'b0;
		steps = 0;
		if (k == 0 || k == n) begin
			coef = 1;
		end else if (n == 0 || k > n) begin
			coef = '0;
		end else begin
			acc = 1;
			for (j = 1; j <= k; j++) begin
				steps++;
				factor = acc_t'(n) - acc_t'(k) + acc_t'(j);
				prod = prod_t'(acc) * prod_t'(factor);
				if (prod[PROD_BITS-1:ACC_BITS] != '0) begin
					ovf = 1'b1;
					acc = '0;
					break;
				end
				acc = prod[ACC_BITS-1:0] / acc_t'(j);
			end
			coef = acc;
		end
	endfunction

	task automatic send_binomial(input arg_t n, input arg_t k);
		binom_result_t item;
		int steps;
		item.n = n;
		item.k = k;
		compute_binomial(n, k, item.coefficient, item.overflow, steps);
		in_valid <= 1'b1;
		n_value <= n;
		k_value <= k;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(item);
		items_sent++;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Random arguments from a mix of categories; anything that would keep the
	// block busy for too many steps is drawn again.
	function automatic void pick_arguments(output arg_t n, output arg_t k);
		acc_t coef;
		logic ovf;
		int steps;
		int unsigned sel;
		do begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				n = arg_t'($urandom());
				k = '0;
			end else if (sel < 18) begin
				n = arg_t'($urandom());
				k = n;
			end else if (sel < 28) begin
				n = arg_t'($urandom_range(0, 65534));
				k = arg_t'($urandom_range(int'(n) + 1, 65535));
			end else if (sel < 58) begin
				n = arg_t'($urandom());
				k = arg_t'($urandom_range(1, 12));
			end else if (sel < 78) begin
				n = arg_t'($urandom_range(2, 68));
				k = arg_t'($urandom_range(1, int'(n) - 1));
			end else begin
				n = arg_t'($urandom());
				k = arg_t'($urandom());
			end
			compute_binomial(n, k, coef, ovf, steps);
		end while (steps > MAX_RANDOM_STEPS);
	endfunction

	task automatic test_trivial_cases();
		send_binomial(16'd0, 16'd0);
		send_binomial(16'd0, 16'd1);
		send_binomial(16'd0, 16'hFFFF);
		send_binomial(16'hFFFF, 16'd0);
		send_binomial(16'hFFFF, 16'hFFFF);
		send_binomial(16'd1, 16'd1);
		send_binomial(16'd1, 16'd0);
		send_binomial(16'd3, 16'd4);
		send_binomial(16'd100, 16'hFFFF);
		send_binomial(16'hFFFE, 16'hFFFF);
	endtask

	task automatic test_exact_and_overflow();
		send_binomial(16'hFFFF, 16'd1);
		send_binomial(16'd2, 16'd1);
		send_binomial(16'd7, 16'd3);
		send_binomial(16'd20, 16'd19);
		send_binomial(16'hFFFF, 16'd2);
		send_binomial(16'hFFFF, 16'd3);
		send_binomial(16'hFFFF, 16'd4);
		send_binomial(16'hFFFF, 16'd5);
		send_binomial(16'hFFFF, 16'h8000);
		send_binomial(16'd34, 16'd17);
		send_binomial(16'd60, 16'd30);
		send_binomial(16'd62, 16'd31);
		send_binomial(16'd66, 16'd33);
		send_binomial(16'd67, 16'd33);
		send_binomial(16'd68, 16'd34);
	endtask

	task automatic test_random_mix(input int count);
		arg_t n;
		arg_t k;
		repeat (count) begin
			pick_arguments(n, k);
			send_binomial(n, k);
		end
	endtask

	// The sender holds off until the block has answered everything so far.
	task automatic test_drained_items(input int count);
		arg_t n;
		arg_t k;
		repeat (count) begin
			wait_results_done();
			pick_arguments(n, k);
			send_binomial(n, k);
		end
	endtask

	task automatic test_back_to_back(input int count);
		idling_on = 1'b0;
		test_random_mix(count);
	endtask

	always @(posedge clk) begin
		if (!idling_on) begin
			out_stall <= 1'b0;
			out_stall_left <= 0;
		end else if (out_stall_left > 0) begin
			out_stall_left <= out_stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			out_stall_left <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		binom_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (overflow === 1'b1)
				overflow_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: result item with none expected: coefficient %0d overflow %b",
					$time, coefficient, overflow);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (coefficient !== want.coefficient) begin
					$display("%0t: n=%0d k=%0d coefficient expected %0d actual %0d",
						$time, want.n, want.k, want.coefficient, coefficient);
					mismatch_count++;
				end
				if (overflow !== want.overflow) begin
					$display("%0t: n=%0d k=%0d overflow expected %b actual %b",
						$time, want.n, want.k, want.overflow, overflow);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("binomial_coefficient_multiplicative_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_trivial_cases();
		test_exact_and_overflow();
		test_random_mix(440);
		test_drained_items(30);
		test_back_to_back(70);
		wait_results_done();
		repeat (END_DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d items (trivial, exact, overflow, wide random args)",
			items_sent);
		$display("with %0d results checked, %0d of them overflow, %0d mismatches",
			results_checked, overflow_results, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("binomial_coefficient_multiplicative_unit verification clean");
		else
			$display("binomial_coefficient_multiplicative_unit verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/bcm_pkg.sv
rtl/core/bcm_mul.sv
rtl/core/bcm_div.sv
rtl/core/binomial_coefficient_multiplicative_unit.sv
dv/binomial_coefficient_multiplicative_unit_test.sv
